// ----- rtl/core/fpst_pkg.sv -----
// fpst_pkg: shared widths, request codes and unit types of the prefix sum table
// used by fpst_unit and fenwick_prefix_sum_table
`default_nettype none

package fpst_pkg;

    localparam int unsigned CELL_W    = 32;
    localparam int unsigned POS_W     = 11;
    localparam int unsigned IDX_W     = 12;
    localparam int unsigned MAX_INDEX = 1024;
    localparam int unsigned DEPTH     = MAX_INDEX;
    localparam int unsigned ADDR_W    = $clog2(DEPTH);

    localparam logic [POS_W-1:0] TOP_RESET = POS_W'(MAX_INDEX);
    localparam logic [POS_W-1:0] TOP_MAX   = POS_W'(MAX_INDEX);
    localparam logic [IDX_W-1:0] IDX_MAX   = IDX_W'(MAX_INDEX);

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic              walk_up;
        logic [IDX_W-1:0]  idx;
        logic [CELL_W-1:0] a;
        logic [CELL_W-1:0] b;
    } unit_op_t;

    typedef struct packed {
        logic [CELL_W-1:0] sum;
        logic [IDX_W-1:0]  next_idx;
    } unit_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/fpst_ram.sv -----
// fpst_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module fpst_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/fpst_unit.sv -----
// fpst_unit: shared 32-bit adder and tree index stepper (lowest set bit walk)
// depends on fpst_pkg
`default_nettype none

module fpst_unit (
    input  wire fpst_pkg::unit_op_t  op,
    output fpst_pkg::unit_res_t      res
);

    logic [fpst_pkg::IDX_W-1:0] low_bit;

    always_comb begin
        low_bit      = op.idx & (~op.idx + fpst_pkg::IDX_W'(1));
        res.sum      = op.a + op.b;
        res.next_idx = op.walk_up ? (op.idx + low_bit) : (op.idx - low_bit);
    end

endmodule

`default_nettype wire

// ----- rtl/core/fenwick_prefix_sum_table.sv -----
// fenwick_prefix_sum_table: binary indexed tree of 32-bit counters, add and prefix query
// depends on fpst_pkg, fpst_ram, fpst_unit
//
// usage:
//   s_ channel takes a request (req_type, position, delta); add requests give no
//   result, query requests give one m_prefix_sum transfer on the m_ channel.
//   cfg_ channel writes top_index; write it only while the block is idle.
// timing:
//   after reset the tree ram is cleared one cell a cycle, all 1024 cells, and
//   s_ready stays low meanwhile; cfg writes are taken at any time.
//   a request walks one tree cell per cycle through the ram read port; an add
//   walks up to the top index, a query walks down one cell per set bit of position;
//   after the last cell a query's result goes through the finish state to the output
//   register. position zero queries go straight to finish; no-op adds walk no cell.
//   s_ready is low while a walk runs; the result sits in an output register,
//   so a new request is taken while it waits. a query that finishes while the
//   previous result is still stalled holds until m_ready frees the register.
`default_nettype none

module fenwick_prefix_sum_table (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [fpst_pkg::POS_W-1:0]    s_position,
    input  wire logic signed [fpst_pkg::CELL_W-1:0] s_delta,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [fpst_pkg::CELL_W-1:0] m_prefix_sum,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fpst_pkg::POS_W-1:0]    cfg_data
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_STEP   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [fpst_pkg::ADDR_W-1:0]   clr_reg, clr_next;
    logic [fpst_pkg::POS_W-1:0]    top_reg;
    logic [fpst_pkg::POS_W-1:0]    limit_reg, limit_next;
    logic                          query_reg, query_next;
    logic [fpst_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [fpst_pkg::CELL_W-1:0]   delta_reg, delta_next;
    logic [fpst_pkg::CELL_W-1:0]   sum_reg, sum_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fpst_pkg::CELL_W-1:0]   m_data_reg, m_data_next;

    logic [fpst_pkg::POS_W-1:0]    cur_limit;
    logic                          in_transfer;
    logic                          in_range;
    logic                          walk_more;

    logic                          ram_we;
    logic [fpst_pkg::ADDR_W-1:0]   ram_waddr;
    logic [fpst_pkg::CELL_W-1:0]   ram_wdata;
    logic [fpst_pkg::ADDR_W-1:0]   ram_raddr;
    logic [fpst_pkg::CELL_W-1:0]   ram_rdata;

    fpst_pkg::unit_op_t            unit_op;
    fpst_pkg::unit_res_t           unit_res;

    fpst_ram #(
        .WIDTH (fpst_pkg::CELL_W),
        .DEPTH (fpst_pkg::DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpst_unit u_unit (
        .op  (unit_op),
        .res (unit_res)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_prefix_sum = m_data_reg;
    assign in_transfer  = s_valid && s_ready;
    assign cur_limit    = (top_reg > fpst_pkg::TOP_MAX) ? fpst_pkg::TOP_MAX : top_reg;
    assign in_range     = (idx_reg <= fpst_pkg::IDX_MAX);

    always_comb begin
        unit_op.walk_up = !query_reg;
        unit_op.idx     = idx_reg;
        unit_op.a       = query_reg ? sum_reg : ram_rdata;
        unit_op.b       = query_reg ? (in_range ? ram_rdata : '0) : delta_reg;
    end

    assign walk_more = query_reg ? (unit_res.next_idx != '0)
                                 : (unit_res.next_idx <= {1'b0, limit_reg});

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        limit_next   = limit_reg;
        query_next   = query_reg;
        idx_next     = idx_reg;
        delta_next   = delta_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[fpst_pkg::ADDR_W-1:0];
        ram_wdata    = unit_res.sum;
        ram_raddr    = s_position[fpst_pkg::ADDR_W-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + fpst_pkg::ADDR_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_transfer) begin
                    query_next = (s_req_type == fpst_pkg::REQ_QUERY);
                    idx_next   = {1'b0, s_position};
                    delta_next = s_delta;
                    sum_next   = '0;
                    limit_next = cur_limit;
                    if (s_req_type == fpst_pkg::REQ_QUERY) begin
                        state_next = (s_position == '0) ? ST_FINISH : ST_STEP;
                    end else if (s_position != '0 && s_position <= cur_limit) begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                ram_raddr = unit_res.next_idx[fpst_pkg::ADDR_W-1:0];
                ram_we    = !query_reg;
                idx_next  = unit_res.next_idx;
                if (query_reg) begin
                    sum_next = unit_res.sum;
                end
                if (!walk_more) begin
                    state_next = query_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            top_reg     <= fpst_pkg::TOP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                top_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg  <= limit_next;
        query_reg  <= query_next;
        idx_reg    <= idx_next;
        delta_reg  <= delta_next;
        sum_reg    <= sum_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    a_add_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && !query_reg) |-> (idx_reg <= {1'b0, limit_reg}))
        else $error("add walk writes past the top index");

    a_step_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (idx_reg != '0))
        else $error("tree walk reached index zero");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside of query finish");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_ready && !m_valid_reg))
        else $error("transfer possible during tree clear");
`endif

endmodule

`default_nettype wire
